// ----- rtl/bgc_pkg.sv -----
// Package for the button gesture classifier: types, constants and helpers.
// Used by the channel interfaces, controller, datapath and top level.
package bgc_pkg;

  localparam int unsigned SLOT_COUNT = 4;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_RELEASED = 2'd0,
    MODE_PRESSED  = 2'd1,
    MODE_LONG     = 2'd2,
    MODE_DOUBLE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_LONG    = 2'd1,
    EV_RELEASE = 2'd2,
    EV_DOUBLE  = 2'd3
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS   = 2'd0,
    CFG_DOUBLE_WIN   = 2'd1,
    CFG_ACTIVE_LEVEL = 2'd2,
    CFG_ENABLE_MASK  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EMIT = 2'd2
  } state_e;

  typedef struct packed {
    logic              load;
    logic              step;
    logic              emit;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_COUNT-1:0] ev_valid;
    logic                  out_free;
  } status_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
  endfunction

endpackage

// ----- rtl/bgc_if.sv -----
// Valid/ready channel interfaces for scan ticks and gesture events.
// Depends on bgc_pkg for field widths.
interface bgc_in_if;
  logic                             valid;
  logic                             ready;
  logic [bgc_pkg::SLOT_COUNT-1:0]   pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

interface bgc_out_if;
  logic                         valid;
  logic                         ready;
  logic [bgc_pkg::SLOT_W-1:0]   button_index;
  logic [1:0]                   event_code;
  logic                         last_event;

  modport source (output valid, output button_index, output event_code,
                  output last_event, input ready);
  modport sink   (input valid, input button_index, input event_code,
                  input last_event, output ready);
endinterface

// ----- rtl/bgc_ctrl.sv -----
// Sequencer for the gesture classifier: load, scan each slot, emit events.
// Depends on bgc_pkg; drives the datapath through cmd_t, reads status_t.
module bgc_ctrl
  import bgc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  localparam logic [SLOT_W-1:0] LastSlot = SLOT_W'(SLOT_COUNT - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.slot = slot_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          slot_d     = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        slot_d     = slot_q + 1'b1;
        if (slot_q == LastSlot) begin
          slot_d  = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status_i.ev_valid[slot_q] || status_i.out_free) begin
          cmd_o.emit = status_i.ev_valid[slot_q];
          slot_d     = slot_q + 1'b1;
          if (slot_q == LastSlot) begin
            slot_d  = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/bgc_datapath.sv -----
// Per-slot gesture state, configuration registers, event buffer, output register.
// Depends on bgc_pkg; commanded by bgc_ctrl.
module bgc_datapath
  import bgc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic [SLOT_COUNT-1:0] pin_levels_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SLOT_W-1:0]     out_index_o,
  output logic [1:0]            out_code_o,
  output logic                  out_last_o
);

  logic [COUNT_W-1:0]    long_ticks_q;
  logic [COUNT_W-1:0]    win_ticks_q;
  logic                  active_level_q;
  logic [SLOT_COUNT-1:0] enable_q;

  mode_e                 mode_q [SLOT_COUNT];
  logic [COUNT_W-1:0]    hold_q [SLOT_COUNT];
  logic [COUNT_W-1:0]    gap_q  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] pend_q;

  logic [SLOT_COUNT-1:0] pins_q;
  logic [SLOT_COUNT-1:0] ev_valid_q;
  event_e                ev_code_q [SLOT_COUNT];

  logic                  out_valid_q;
  logic [SLOT_W-1:0]     out_index_q;
  event_e                out_code_q;
  logic                  out_last_q;

  mode_e                 mode_d;
  logic [COUNT_W-1:0]    hold_d;
  logic [COUNT_W-1:0]    gap_d;
  logic                  pend_d;
  logic                  ev_d;
  event_e                code_d;
  logic                  active;
  logic                  enabled;
  logic [SLOT_COUNT-1:0] later_ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q   <= COUNT_W'(100);
      win_ticks_q    <= COUNT_W'(30);
      active_level_q <= 1'b0;
      enable_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LONG_PRESS:   long_ticks_q   <= cfg_data_i[COUNT_W-1:0];
        CFG_DOUBLE_WIN:   win_ticks_q    <= cfg_data_i[COUNT_W-1:0];
        CFG_ACTIVE_LEVEL: active_level_q <= cfg_data_i[0];
        CFG_ENABLE_MASK:  enable_q       <= cfg_data_i[SLOT_COUNT-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    enabled = enable_q[cmd_i.slot];
    active  = (pins_q[cmd_i.slot] == active_level_q);
    mode_d  = mode_q[cmd_i.slot];
    hold_d  = hold_q[cmd_i.slot];
    gap_d   = gap_q[cmd_i.slot];
    pend_d  = pend_q[cmd_i.slot];
    ev_d    = 1'b0;
    code_d  = EV_PRESS;
    if (pend_d) begin
      gap_d = sat_inc(gap_d);
      if (gap_d > win_ticks_q) begin
        pend_d = 1'b0;
        gap_d  = '0;
      end
    end
    if (active) begin
      if (mode_d == MODE_RELEASED) begin
        mode_d = MODE_PRESSED;
        hold_d = '0;
        ev_d   = 1'b1;
        code_d = EV_PRESS;
      end else if (mode_d == MODE_PRESSED) begin
        hold_d = sat_inc(hold_d);
        if (hold_d >= long_ticks_q) begin
          mode_d = MODE_LONG;
          ev_d   = 1'b1;
          code_d = EV_LONG;
        end
      end
    end else if (mode_d == MODE_PRESSED) begin
      ev_d = 1'b1;
      if (pend_d) begin
        mode_d = MODE_DOUBLE;
        pend_d = 1'b0;
        gap_d  = '0;
        code_d = EV_DOUBLE;
      end else begin
        mode_d = MODE_RELEASED;
        hold_d = '0;
        pend_d = 1'b1;
        gap_d  = '0;
        code_d = EV_RELEASE;
      end
    end else begin
      mode_d = MODE_RELEASED;
      hold_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        mode_q[i] <= MODE_RELEASED;
        hold_q[i] <= '0;
        gap_q[i]  <= '0;
      end
      pend_q     <= '0;
      ev_valid_q <= '0;
    end else if (cmd_i.load) begin
      ev_valid_q <= '0;
    end else if (cmd_i.step && enabled) begin
      mode_q[cmd_i.slot]     <= mode_d;
      hold_q[cmd_i.slot]     <= hold_d;
      gap_q[cmd_i.slot]      <= gap_d;
      pend_q[cmd_i.slot]     <= pend_d;
      ev_valid_q[cmd_i.slot] <= ev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pins_q <= pin_levels_i;
    end
    if (cmd_i.step) begin
      ev_code_q[cmd_i.slot] <= code_d;
    end
  end

  assign later_ev = (ev_valid_q >> cmd_i.slot) >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_index_q <= cmd_i.slot;
      out_code_q  <= ev_code_q[cmd_i.slot];
      out_last_q  <= (later_ev == '0);
    end
  end

  assign status_o.ev_valid = ev_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_index_o       = out_index_q;
  assign out_code_o        = out_code_q;
  assign out_last_o        = out_last_q;

endmodule

// ----- rtl/button_gesture_classifier_core.sv -----
// Button gesture classifier top level: controller, datapath, channel ports.
// Depends on bgc_pkg, bgc_in_if, bgc_out_if, bgc_ctrl and bgc_datapath.
//
// Usage:
//   in_ch carries one scan tick (pin_levels, one bit per button slot).
//   out_ch carries gesture events: button_index, event_code (press, long
//   press, short release, double press) and last_event, set on the final
//   event caused by a tick. A tick causes zero to four events.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) set the long
//   press threshold, the double click window, the active pin level and
//   the slot enable mask; write them while no tick is in flight.
//   Timing: a tick is transferred in the idle state, then the scan state
//   visits the slots in order, then the emit state offers the buffered
//   events one slot per cycle while out_ch does not stall. A stalled
//   receiver holds the event in the output register and the sequencer
//   waits on the next event only.
//   Reset clears all slot state and loads the register defaults
//   (threshold 100, window 30, active level low, no slot enabled).
module button_gesture_classifier_core
  import bgc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  bgc_in_if.sink               in_ch,
  bgc_out_if.source            out_ch
);

  cmd_t    cmd;
  status_t status;

  bgc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bgc_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pin_levels_i (in_ch.pin_levels),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_index_o  (out_ch.button_index),
    .out_code_o   (out_ch.event_code),
    .out_last_o   (out_ch.last_event)
  );

endmodule

// ----- rtl/bgc_checker.sv -----
// Port-level checks for the button gesture classifier, bound to the top level.
// Depends on bgc_pkg for widths.
module bgc_checker
  import bgc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [SLOT_W-1:0] out_index_i,
  input logic [1:0]        out_code_i,
  input logic              out_last_i
);

  a_busy_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready after a tick transfer");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("event valid right after reset");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("stalled event dropped");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_index_i) && $stable(out_code_i) && $stable(out_last_i))
    else $error("stalled event changed");

endmodule

bind button_gesture_classifier_core bgc_checker u_bgc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_index_i (out_ch.button_index),
  .out_code_i  (out_ch.event_code),
  .out_last_i  (out_ch.last_event)
);

// ----- dv/bgc_gesture_checker.sv -----
// Scoreboard for the button gesture classifier: snoops config writes and both channels,
// predicts the gesture events of every scan tick and compares them in order.
// Depends on bgc_pkg, bgc_in_if and bgc_out_if.
module bgc_gesture_checker
  import bgc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  bgc_in_if                    in_ch,
  bgc_out_if                   out_ch,
  output int unsigned          errors_o,
  output int unsigned          expected_left_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    event_e            code;
    logic              last;
  } gesture_t;

  gesture_t           gesture_q[$];
  gesture_t           want;
  mode_e              slot_mode [SLOT_COUNT];
  logic [COUNT_W-1:0] hold_cnt  [SLOT_COUNT];
  logic [COUNT_W-1:0] gap_cnt   [SLOT_COUNT];
  logic               click_wait[SLOT_COUNT];
  logic [CFG_W-1:0]   long_thr;
  logic [CFG_W-1:0]   dbl_win;
  logic               act_lvl;
  logic [SLOT_COUNT-1:0] en_mask;
  int unsigned        errors = 0;

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic void classify_tick(input logic [SLOT_COUNT-1:0] pins);
    gesture_t tick_events[$];
    gesture_t ev;
    logic     active;
    logic     hit;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (!en_mask[s]) continue;
      active = (pins[s] == act_lvl);
      hit    = 1'b0;
      ev     = '0;
      if (click_wait[s]) begin
        gap_cnt[s] = bump(gap_cnt[s]);
        if (gap_cnt[s] > dbl_win) begin
          click_wait[s] = 1'b0;
          gap_cnt[s]    = '0;
        end
      end
      if (active) begin
        if (slot_mode[s] == MODE_RELEASED) begin
          slot_mode[s] = MODE_PRESSED;
          hold_cnt[s]  = '0;
          hit          = 1'b1;
          ev.code      = EV_PRESS;
        end else if (slot_mode[s] == MODE_PRESSED) begin
          hold_cnt[s] = bump(hold_cnt[s]);
          if (hold_cnt[s] >= long_thr) begin
            slot_mode[s] = MODE_LONG;
            hit          = 1'b1;
            ev.code      = EV_LONG;
          end
        end
      end else if (slot_mode[s] == MODE_PRESSED) begin
        hit = 1'b1;
        if (click_wait[s]) begin
          slot_mode[s]  = MODE_DOUBLE;
          click_wait[s] = 1'b0;
          gap_cnt[s]    = '0;
          ev.code       = EV_DOUBLE;
        end else begin
          slot_mode[s]  = MODE_RELEASED;
          hold_cnt[s]   = '0;
          click_wait[s] = 1'b1;
          gap_cnt[s]    = '0;
          ev.code       = EV_RELEASE;
        end
      end else begin
        slot_mode[s] = MODE_RELEASED;
        hold_cnt[s]  = '0;
      end
      if (hit) begin
        ev.slot = SLOT_W'(s);
        tick_events.push_back(ev);
      end
    end
    if (tick_events.size() != 0) tick_events[tick_events.size()-1].last = 1'b1;
    foreach (tick_events[k]) gesture_q.push_back(tick_events[k]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
        slot_mode[s]  = MODE_RELEASED;
        hold_cnt[s]   = '0;
        click_wait[s] = 1'b0;
        gap_cnt[s]    = '0;
      end
      long_thr = 16'd100;
      dbl_win  = 16'd30;
      act_lvl  = 1'b0;
      en_mask  = '0;
      gesture_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_LONG_PRESS:   long_thr = cfg_data_i;
          CFG_DOUBLE_WIN:   dbl_win  = cfg_data_i;
          CFG_ACTIVE_LEVEL: act_lvl  = cfg_data_i[0];
          CFG_ENABLE_MASK:  en_mask  = cfg_data_i[SLOT_COUNT-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) classify_tick(in_ch.pin_levels);
      if (out_ch.valid && out_ch.ready) begin
        if (gesture_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected event slot %0d code %0d last %0d", $time,
                   out_ch.button_index, out_ch.event_code, out_ch.last_event);
        end else begin
          want = gesture_q.pop_front();
          if (out_ch.button_index !== want.slot) begin
            errors++;
            $display("%0t: button_index mismatch: expected %0d, actual %0d", $time,
                     want.slot, out_ch.button_index);
          end
          if (out_ch.event_code !== want.code) begin
            errors++;
            $display("%0t: event_code mismatch: expected %0d, actual %0d", $time,
                     want.code, out_ch.event_code);
          end
          if (out_ch.last_event !== want.last) begin
            errors++;
            $display("%0t: last_event mismatch: expected %0d, actual %0d", $time,
                     want.last, out_ch.last_event);
          end
        end
      end
    end
    errors_o        <= errors;
    expected_left_o <= gesture_q.size();
  end

endmodule

// ----- dv/button_gesture_classifier_core_tb.sv -----
// Top of the button gesture classifier bench: clock, reset, config writes,
// scan tick stimulus, receiver stalls, watchdog and verdict.
// Depends on bgc_pkg, bgc_in_if, bgc_out_if, bgc_gesture_checker and the core.
module button_gesture_classifier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bgc_pkg::*;

  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned STALL_CYCLES    = 300;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned NEVER           = 32'hFFFF_FFFF;

  localparam logic [SLOT_COUNT-1:0] BASIC_TICKS [17] = '{
    4'hF, 4'hF, 4'hF, 4'hF, 4'h0, 4'h5, 4'h0, 4'h5, 4'h0,
    4'h0, 4'h1, 4'h0, 4'h0, 4'h0, 4'h0, 4'h1, 4'h0
  };
  localparam logic [SLOT_COUNT-1:0] ZERO_REG_TICKS [7] = '{
    4'hE, 4'hE, 4'hF, 4'hE, 4'hF, 4'hE, 4'hF
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  int unsigned mismatches;
  int unsigned events_due;
  bit          idle_on;
  int unsigned stall_reqs   = 0;
  int unsigned stall_seen   = 0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;

  logic             drive_level;
  logic [CFG_W-1:0] drive_long;
  bit               held     [SLOT_COUNT];
  int unsigned      run_left [SLOT_COUNT];

  bgc_in_if  tick_ch ();
  bgc_out_if gesture_ch ();

  button_gesture_classifier_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (tick_ch),
    .out_ch     (gesture_ch)
  );

  bgc_gesture_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_ch           (tick_ch),
    .out_ch          (gesture_ch),
    .errors_o        (mismatches),
    .expected_left_o (events_due)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // hold off the receiver for a long stretch on request
  always @(posedge clk_i) begin
    if (stall_seen != stall_reqs) begin
      stall_seen       <= stall_reqs;
      stall_left       <= STALL_CYCLES;
      gesture_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left       <= stall_left - 1;
      gesture_ch.ready <= 1'b0;
    end else begin
      gesture_ch.ready <= !(idle_on && ($urandom_range(0, 99) < 9));
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (tick_ch.valid && tick_ch.ready) || (gesture_ch.valid && gesture_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input logic [SLOT_COUNT-1:0] pins);
    if (idle_on && ($urandom_range(0, 99) < 9)) begin
      tick_ch.valid <= 1'b0;
      do @(posedge clk_i); while (idle_on && ($urandom_range(0, 99) < 9));
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.pin_levels <= pins;
    do @(posedge clk_i); while (!tick_ch.ready);
  endtask

  task automatic drain();
    tick_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (events_due != 0) @(posedge clk_i);
  endtask

  task automatic setup(input logic [CFG_W-1:0] long_v, input logic [CFG_W-1:0] win_v,
                       input logic lvl, input logic [SLOT_COUNT-1:0] mask);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LONG_PRESS;
    cfg_data_i <= long_v;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DOUBLE_WIN;
    cfg_data_i <= win_v;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ACTIVE_LEVEL;
    cfg_data_i <= CFG_W'(lvl);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ENABLE_MASK;
    cfg_data_i <= CFG_W'(mask);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    drive_level = lvl;
    drive_long  = long_v;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      held[s]     = 1'b0;
      run_left[s] = 0;
    end
  endtask

  // hold each button for runs of up to the long press threshold plus three,
  // capped at 16 ticks, with an occasional tick of random noise
  function automatic logic [SLOT_COUNT-1:0] next_pins();
    logic [SLOT_COUNT-1:0] pins;
    int unsigned           max_run;
    max_run = (drive_long + 3 < 16) ? drive_long + 3 : 16;
    if ($urandom_range(0, 7) == 0) return SLOT_COUNT'($urandom_range(0, 15));
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (run_left[s] == 0) begin
        held[s] = !held[s];
        if (held[s]) run_left[s] = $urandom_range(1, max_run);
        else run_left[s] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
                                                       : $urandom_range(1, 4);
      end
      run_left[s]--;
      pins[s] = held[s] ? drive_level : !drive_level;
    end
    return pins;
  endfunction

  task automatic run_random(input int unsigned count, input int unsigned stall_at,
                            input int unsigned pause_at);
    for (int unsigned n = 0; n < count; n++) begin
      if (n == stall_at) stall_reqs <= stall_reqs + 1;
      if (n == pause_at) drain();
      send_tick(next_pins());
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_LONG_PRESS;
    cfg_data_i         <= '0;
    tick_ch.valid      <= 1'b0;
    tick_ch.pin_levels <= '0;
    idle_on = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    setup(16'd3, 16'd2, 1'b1, 4'hF);
    foreach (BASIC_TICKS[i]) send_tick(BASIC_TICKS[i]);

    setup(16'd1000, 16'd2, 1'b1, 4'h3);
    repeat (4) send_tick(4'h3);
    setup(16'd2, 16'd2, 1'b1, 4'h3);
    send_tick(4'h1);

    setup(16'd0, 16'd0, 1'b0, 4'hF);
    foreach (ZERO_REG_TICKS[i]) send_tick(ZERO_REG_TICKS[i]);

    setup(CFG_W'($urandom_range(2, 6)), CFG_W'($urandom_range(2, 8)), 1'b1, 4'hF);
    run_random(60, 20, NEVER);

    setup(16'hFFFF, 16'hFFFF, 1'b0, 4'hF);
    run_random(40, NEVER, 25);

    setup(16'd1, 16'd1, 1'b0, SLOT_COUNT'($urandom_range(1, 15)));
    run_random(50, NEVER, NEVER);

    setup(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 12)),
          1'($urandom_range(0, 1)), SLOT_COUNT'($urandom_range(1, 15)));
    run_random(60, 15, 40);

    idle_on = 1'b0;
    setup(CFG_W'($urandom_range(2, 10)), CFG_W'($urandom_range(2, 10)), 1'b1, 4'hF);
    run_random(60, NEVER, NEVER);
    idle_on = 1'b1;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && events_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bgc_pkg.sv
rtl/bgc_if.sv
rtl/bgc_ctrl.sv
rtl/bgc_datapath.sv
rtl/button_gesture_classifier_core.sv
rtl/bgc_checker.sv
dv/bgc_gesture_checker.sv
dv/button_gesture_classifier_core_tb.sv
